/* hdl/fti_pkg.sv */
package fti_pkg;

    // Item operations
    typedef enum logic [1:0] {
        OP_WRITE_NODE    = 2'd0,
        OP_WRITE_FEATURE = 2'd1,
        OP_SET_ROOT      = 2'd2,
        OP_PREDICT       = 2'd3
    } op_t;

    // Split node kinds
    localparam logic [2:0] KIND_CELL     = 3'd0;
    localparam logic [2:0] KIND_DRUG     = 3'd1;
    localparam logic [2:0] KIND_PAIR_MIN = 3'd2;
    localparam logic [2:0] KIND_PAIR_MAX = 3'd3;
    localparam logic [2:0] KIND_PAIR_AVG = 3'd4;

    // Vector selects
    localparam logic [1:0] VSEL_CELL  = 2'd0;
    localparam logic [1:0] VSEL_DRUG  = 2'd1;
    localparam logic [1:0] VSEL_DRUG2 = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_BAD_KIND  = 2'd2,
        ST_LONG_WALK = 2'd3
    } status_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_NUM_TREES = 2'd0;
    localparam logic [1:0] CFG_NUM_CELL  = 2'd1;
    localparam logic [1:0] CFG_NUM_DRUG  = 2'd2;
    localparam logic [1:0] CFG_PAIR_MODE = 2'd3;

    // Field widths fixed by the item format, and the sum accumulator width
    localparam int ADDR_W  = 10;
    localparam int FIDX_W  = 8;
    localparam int CFG_W   = 9;
    localparam int SUM_W   = 40;

    // Table sizes and value width, tied to the item format
    localparam int NODE_COUNT   = 1024;
    localparam int MAX_FEATURES = 256;
    localparam int VALUE_BITS   = 32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROOT_RD,
        S_ROOT_WAIT,
        S_NODE_RD,
        S_NODE_WAIT,
        S_FEAT_WAIT,
        S_COMPARE,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } state_t;

endpackage

/* hdl/fti_stream_if.sv */
interface fti_in_if;
    import fti_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [9:0]  target_address;
    logic        node_is_leaf;
    logic [2:0]  node_kind;
    logic [7:0]  split_feature_index;
    logic signed [31:0] split_threshold;
    logic [9:0]  left_child;
    logic [9:0]  right_child;
    logic signed [31:0] leaf_value;
    logic [1:0]  vector_select;
    logic signed [31:0] feature_value;
    logic [9:0]  root_address;

    modport source (output valid, operation, target_address, node_is_leaf, node_kind,
        split_feature_index, split_threshold, left_child, right_child, leaf_value,
        vector_select, feature_value, root_address, input ready);
    modport sink (input valid, operation, target_address, node_is_leaf, node_kind,
        split_feature_index, split_threshold, left_child, right_child, leaf_value,
        vector_select, feature_value, root_address, output ready);
endinterface

interface fti_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] prediction;
    logic [1:0]  status;

    modport source (output valid, prediction, status, input ready);
    modport sink (input valid, prediction, status, output ready);
endinterface

interface fti_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [8:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hdl/forest_tree_inference_core.sv */
// Operation: write items are taken one per cycle, back to back, while no prediction is
//   in flight. A prediction reads each tree's root, then per node a node read, a feature
//   read and a compare; the mean is a 41-step bit-serial divide; an error ends sooner.
// Throughput: one prediction at a time; input is held off until its result is taken.
// Reset: control and configuration registers return to reset values (num_trees 1,
//   lengths 0, single mode); node, root and feature memories are undefined until written.
module forest_tree_inference_core
    import fti_pkg::*;
#(
    parameter int MAX_TREES    = 64
)(
    input  logic       clk,
    input  logic       rst_n,
    fti_in_if.sink     in_ch,
    fti_out_if.source  out_ch,
    fti_cfg_if.sink    cfg
);

    localparam int NA_W = $clog2(NODE_COUNT);
    localparam int TR_W = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int FE_W = $clog2(MAX_FEATURES);
    localparam int ST_W = $clog2(NODE_COUNT + 1);
    localparam int NT_W = $clog2(MAX_TREES + 1);
    localparam int DV_W = SUM_W + 1;
    localparam int DC_W = $clog2(DV_W + 1);

    typedef struct packed {
        logic                  leaf;
        logic [2:0]            kind;
        logic [FIDX_W-1:0]     fidx;
        logic [VALUE_BITS-1:0] thr;
        logic [ADDR_W-1:0]     left;
        logic [ADDR_W-1:0]     right;
        logic [VALUE_BITS-1:0] lval;
    } node_t;

    // Memories
    node_t                 node_mem  [NODE_COUNT];
    logic [ADDR_W-1:0]     root_mem  [MAX_TREES];
    logic [VALUE_BITS-1:0] cell_mem  [MAX_FEATURES];
    logic [VALUE_BITS-1:0] drug_mem  [MAX_FEATURES];
    logic [VALUE_BITS-1:0] drug2_mem [MAX_FEATURES];

    node_t                 node_rd;
    logic [ADDR_W-1:0]     root_rd;
    logic [VALUE_BITS-1:0] cell_rd, drug_rd, drug2_rd;

    // Config registers
    logic [6:0]       num_trees_reg;
    logic [CFG_W-1:0] ncell_reg, ndrug_reg;
    logic             pair_reg;

    // Control and datapath registers
    state_t                state_reg, state_next;
    logic [TR_W-1:0]       tree_reg, tree_next;
    logic [NT_W-1:0]       tcount_reg, tcount_next;
    logic [NA_W-1:0]       idx_reg, idx_next;
    logic [ST_W-1:0]       steps_reg, steps_next;
    node_t                 cur_reg, cur_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [VALUE_BITS-1:0] pred_reg, pred_next;
    status_t               stat_reg, stat_next;
    logic                  neg_reg, neg_next;
    logic [DV_W-1:0]       rem_reg, rem_next;
    logic [DV_W-1:0]       quo_reg, quo_next;
    logic [DC_W-1:0]       dcnt_reg, dcnt_next;

    logic in_fire, cfg_fire;
    logic [NT_W-1:0] nt_eff;
    logic [CFG_W-1:0] ncell_eff, ndrug_eff;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign cfg_fire    = cfg.valid && cfg.ready;

    assign out_ch.valid      = (state_reg == S_DONE);
    assign out_ch.prediction = pred_reg;
    assign out_ch.status     = stat_reg;

    // Effective tree count and feature lengths
    always_comb
    begin
        if (num_trees_reg == 7'd0)
            nt_eff = NT_W'(1);
        else if (32'(num_trees_reg) > MAX_TREES)
            nt_eff = NT_W'(MAX_TREES);
        else
            nt_eff = NT_W'(num_trees_reg);
        ncell_eff = (32'(ncell_reg) > MAX_FEATURES) ? CFG_W'(MAX_FEATURES) : ncell_reg;
        ndrug_eff = (32'(ndrug_reg) > MAX_FEATURES) ? CFG_W'(MAX_FEATURES) : ndrug_reg;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_trees_reg <= 7'd1;
            ncell_reg     <= '0;
            ndrug_reg     <= '0;
            pair_reg      <= 1'b0;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                CFG_NUM_TREES: num_trees_reg <= cfg.data[6:0];
                CFG_NUM_CELL:  ncell_reg     <= cfg.data;
                CFG_NUM_DRUG:  ndrug_reg     <= cfg.data;
                CFG_PAIR_MODE: pair_reg      <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // Node memory: written by items, read during walks
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.operation == OP_WRITE_NODE)
            node_mem[in_ch.target_address[NA_W-1:0]] <= node_t'{
                leaf:  in_ch.node_is_leaf,
                kind:  in_ch.node_kind,
                fidx:  in_ch.split_feature_index,
                thr:   VALUE_BITS'(in_ch.split_threshold),
                left:  in_ch.left_child,
                right: in_ch.right_child,
                lval:  VALUE_BITS'(in_ch.leaf_value)};
        node_rd <= node_mem[idx_reg];
    end

    // Root table
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.operation == OP_SET_ROOT
            && 32'(in_ch.target_address) < MAX_TREES)
            root_mem[in_ch.target_address[TR_W-1:0]] <= in_ch.root_address;
        root_rd <= root_mem[tree_reg];
    end

    // Feature vectors, read at the current node's feature index
    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.operation == OP_WRITE_FEATURE
            && 32'(in_ch.target_address) < MAX_FEATURES)
        begin
            if (in_ch.vector_select == VSEL_CELL)
                cell_mem[in_ch.target_address[FE_W-1:0]] <= VALUE_BITS'(in_ch.feature_value);
            if (in_ch.vector_select == VSEL_DRUG)
                drug_mem[in_ch.target_address[FE_W-1:0]] <= VALUE_BITS'(in_ch.feature_value);
            if (in_ch.vector_select == VSEL_DRUG2)
                drug2_mem[in_ch.target_address[FE_W-1:0]] <= VALUE_BITS'(in_ch.feature_value);
        end
        cell_rd  <= cell_mem[cur_reg.fidx[FE_W-1:0]];
        drug_rd  <= drug_mem[cur_reg.fidx[FE_W-1:0]];
        drug2_rd <= drug2_mem[cur_reg.fidx[FE_W-1:0]];
    end

    // Feature selection and compare
    logic kind_ok, fidx_ok, go_left;
    logic signed [VALUE_BITS-1:0] fa, fb, fsel;
    logic signed [VALUE_BITS:0]   fsum;

    always_comb
    begin
        fa   = drug_rd;
        fb   = drug2_rd;
        fsum = {fa[VALUE_BITS-1], fa} + {fb[VALUE_BITS-1], fb};
        case (cur_reg.kind)
            KIND_CELL:     kind_ok = 1'b1;
            KIND_DRUG:     kind_ok = !pair_reg;
            KIND_PAIR_MIN,
            KIND_PAIR_MAX,
            KIND_PAIR_AVG: kind_ok = pair_reg;
            default:       kind_ok = 1'b0;
        endcase
        if (cur_reg.kind == KIND_CELL)
            fidx_ok = CFG_W'(cur_reg.fidx) < ncell_eff;
        else
            fidx_ok = CFG_W'(cur_reg.fidx) < ndrug_eff;
        case (cur_reg.kind)
            KIND_CELL:     fsel = cell_rd;
            KIND_DRUG:     fsel = fa;
            KIND_PAIR_MIN: fsel = (fa < fb) ? fa : fb;
            KIND_PAIR_MAX: fsel = (fa > fb) ? fa : fb;
            default:       fsel = fsum[VALUE_BITS:1];
        endcase
        go_left = fsel < $signed(cur_reg.thr);
    end

    // Divider operand: magnitude of the sum
    logic [SUM_W-1:0] sum_mag;
    logic [DV_W-1:0]  trial;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial   = {rem_reg[DV_W-2:0], quo_reg[DV_W-1]};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        tree_next   = tree_reg;
        tcount_next = tcount_reg;
        idx_next    = idx_reg;
        steps_next  = steps_reg;
        cur_next    = cur_reg;
        sum_next    = sum_reg;
        pred_next   = pred_reg;
        stat_next   = stat_reg;
        neg_next    = neg_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dcnt_next   = dcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.operation == OP_PREDICT)
                begin
                    tree_next   = '0;
                    tcount_next = '0;
                    sum_next    = '0;
                    stat_next   = ST_OK;
                    state_next  = S_ROOT_RD;
                end
            end
            S_ROOT_RD:   state_next = S_ROOT_WAIT;
            S_ROOT_WAIT:
            begin
                idx_next   = root_rd[NA_W-1:0];
                steps_next = '0;
                state_next = S_NODE_RD;
            end
            S_NODE_RD:   state_next = S_NODE_WAIT;
            S_NODE_WAIT:
            begin
                cur_next = node_rd;
                if (steps_reg == ST_W'(NODE_COUNT))
                begin
                    stat_next  = ST_LONG_WALK;
                    state_next = S_DONE;
                    pred_next  = '0;
                end
                else if (node_rd.leaf)
                begin
                    sum_next    = sum_reg + SUM_W'($signed(node_rd.lval));
                    tcount_next = tcount_reg + 1'b1;
                    tree_next   = tree_reg + 1'b1;
                    state_next  = (tcount_reg + 1'b1 == nt_eff) ? S_DIV_INIT : S_ROOT_RD;
                end
                else
                    state_next = S_FEAT_WAIT;
            end
            S_FEAT_WAIT: state_next = S_COMPARE;
            S_COMPARE:
            begin
                if (!kind_ok)
                begin
                    stat_next  = ST_BAD_KIND;
                    pred_next  = '0;
                    state_next = S_DONE;
                end
                else if (!fidx_ok)
                begin
                    stat_next  = ST_BAD_INDEX;
                    pred_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = go_left ? cur_reg.left[NA_W-1:0] : cur_reg.right[NA_W-1:0];
                    steps_next = steps_reg + 1'b1;
                    state_next = S_NODE_RD;
                end
            end
            S_DIV_INIT:
            begin
                neg_next   = sum_reg[SUM_W-1];
                quo_next   = DV_W'(sum_mag);
                rem_next   = '0;
                dcnt_next  = DC_W'(DV_W);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring divide, one quotient bit a cycle
                quo_next = {quo_reg[DV_W-2:0], 1'b0};
                if (trial >= DV_W'(nt_eff))
                begin
                    rem_next    = trial - DV_W'(nt_eff);
                    quo_next[0] = 1'b1;
                end
                else
                    rem_next = trial;
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DC_W'(1))
                begin
                    pred_next  = neg_reg ? VALUE_BITS'(-quo_next) : VALUE_BITS'(quo_next);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tree_reg   <= '0;
            tcount_reg <= '0;
            steps_reg  <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tree_reg   <= tree_next;
            tcount_reg <= tcount_next;
            steps_reg  <= steps_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cur_reg  <= cur_next;
        sum_reg  <= sum_next;
        pred_reg <= pred_next;
        stat_reg <= stat_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

`ifndef SYNTHESIS
    // An error result always carries a zero prediction
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_OK) |-> out_ch.prediction == '0)
        else $error("error result with nonzero prediction");

    // Trees counted never exceed the effective count
    a_tcount: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_DONE) |-> tcount_reg <= nt_eff)
        else $error("tree count overran");

    // Walk length bounded by node count
    a_steps: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= ST_W'(NODE_COUNT))
        else $error("walk step count overran");

    // No input taken while a prediction is in flight
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready)
        else $error("ready while busy");
`endif

endmodule

/* sim/tb_top.sv */
module tb_top;
    import fti_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_NODES   = 1024;
    localparam int N_TREES   = 64;
    localparam int N_FEAT    = 256;
    localparam int WDOG_MAX  = 1200000;
    localparam int SETTLE    = 60;

    // what a forest walk needs that has not been written yet
    localparam logic [2:0] MISS_ROOT  = 3'd0;
    localparam logic [2:0] MISS_NODE  = 3'd1;
    localparam logic [2:0] MISS_CELL  = 3'd2;
    localparam logic [2:0] MISS_DRUG  = 3'd3;
    localparam logic [2:0] MISS_DRUG2 = 3'd4;

    typedef struct {
        op_t                op;
        logic [9:0]         addr;
        logic               leaf;
        logic [2:0]         kind;
        logic [7:0]         fidx;
        logic signed [31:0] thr;
        logic [9:0]         lch;
        logic [9:0]         rch;
        logic signed [31:0] lval;
        logic [1:0]         vsel;
        logic signed [31:0] fval;
        logic [9:0]         root;
        bit                 has_pred;
        logic signed [31:0] mean;
        status_t            st;
    } req_t;

    typedef struct {
        logic signed [31:0] mean;
        status_t            st;
    } pred_t;

    logic clk;
    logic rst_n;

    fti_in_if  in_ch();
    fti_out_if out_ch();
    fti_cfg_if cfg_ch();

    forest_tree_inference_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // forest image kept by the testbench
    logic [11:0]        node_ctl   [N_NODES];
    logic signed [31:0] node_thr   [N_NODES];
    logic [19:0]        node_lnk   [N_NODES];
    logic signed [31:0] node_lval  [N_NODES];
    logic [9:0]         root_of    [N_TREES];
    logic signed [31:0] cell_feat  [N_FEAT];
    logic signed [31:0] drug_feat  [N_FEAT];
    logic signed [31:0] drug2_feat [N_FEAT];
    bit node_set [N_NODES];
    bit root_set [N_TREES];
    bit cell_set [N_FEAT];
    bit drug_set [N_FEAT];
    bit drug2_set[N_FEAT];

    logic [6:0] reg_trees;
    logic [8:0] reg_ncell;
    logic [8:0] reg_ndrug;
    logic       reg_pair;

    req_t  send_q[$];
    pred_t mean_q[$];

    int  mism_cnt;
    int  items_sent;
    int  phase_cnt;
    int  st_cnt[4];
    int  gen_cnt;
    int  fill_depth;
    bit  gaps_on;
    int  in_gap;
    int  out_stall;
    int  wdog;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_q();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: if (r < 50) return 32'sh7FFFFFFF; else return 32'sh80000000;
            1: return $urandom;
            default: return $signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
        endcase
    endfunction

    function automatic logic [9:0] pick_node();
        if ($urandom_range(0, 99) < 85)
            return 10'($urandom_range(0, 31));
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic req_t rand_req();
        req_t r;
        r.op   = op_t'($urandom_range(0, 3));
        r.addr = 10'($urandom_range(0, 1023));
        r.leaf = 1'($urandom_range(0, 1));
        r.kind = 3'($urandom_range(0, 7));
        r.fidx = 8'($urandom_range(0, 255));
        r.thr  = rand_q();
        r.lch  = 10'($urandom_range(0, 1023));
        r.rch  = 10'($urandom_range(0, 1023));
        r.lval = rand_q();
        r.vsel = 2'($urandom_range(0, 3));
        r.fval = rand_q();
        r.root = 10'($urandom_range(0, 1023));
        r.has_pred = 1'b0;
        r.mean = '0;
        r.st   = ST_OK;
        return r;
    endfunction

    // Walk the whole forest on the image. Stops at the first entry the walk
    // would read without it having been written.
    function automatic void walk_forest(output status_t st, output logic signed [31:0] mean,
                                        output bit miss, output logic [2:0] what,
                                        output logic [9:0] where);
        int ntr, ncell, ndrug, t, steps;
        logic [9:0]  idx;
        logic [11:0] ctl;
        logic [2:0]  kind;
        logic [7:0]  fi;
        longint acc, v, a, b;
        bit done;
        ntr   = (reg_trees == 0) ? 1 : ((reg_trees > N_TREES) ? N_TREES : int'(reg_trees));
        ncell = (reg_ncell > N_FEAT) ? N_FEAT : int'(reg_ncell);
        ndrug = (reg_ndrug > N_FEAT) ? N_FEAT : int'(reg_ndrug);
        st = ST_OK;
        mean = '0;
        miss = 1'b0;
        what = MISS_ROOT;
        where = '0;
        acc = 0;
        v = 0;
        for (t = 0; t < ntr && st == ST_OK && !miss; t++) begin
            if (!root_set[t]) begin
                miss = 1'b1;
                what = MISS_ROOT;
                where = 10'(t);
            end
            else begin
                idx = root_of[t];
                done = 1'b0;
                for (steps = 0; steps < N_NODES && !done; steps++) begin
                    ctl  = node_ctl[idx];
                    kind = ctl[10:8];
                    fi   = ctl[7:0];
                    if (!node_set[idx]) begin
                        miss = 1'b1; what = MISS_NODE; where = idx; done = 1'b1;
                    end
                    else if (ctl[11]) begin
                        acc += node_lval[idx];
                        done = 1'b1;
                    end
                    else begin
                        if (kind == KIND_CELL) begin
                            if (fi >= ncell) begin st = ST_BAD_INDEX; done = 1'b1; end
                            else if (!cell_set[fi]) begin
                                miss = 1'b1; what = MISS_CELL; where = 10'(fi); done = 1'b1;
                            end
                            else v = cell_feat[fi];
                        end
                        else if (kind == KIND_DRUG && !reg_pair) begin
                            if (fi >= ndrug) begin st = ST_BAD_INDEX; done = 1'b1; end
                            else if (!drug_set[fi]) begin
                                miss = 1'b1; what = MISS_DRUG; where = 10'(fi); done = 1'b1;
                            end
                            else v = drug_feat[fi];
                        end
                        else if (kind >= KIND_PAIR_MIN && kind <= KIND_PAIR_AVG && reg_pair) begin
                            if (fi >= ndrug) begin st = ST_BAD_INDEX; done = 1'b1; end
                            else if (!drug_set[fi]) begin
                                miss = 1'b1; what = MISS_DRUG; where = 10'(fi); done = 1'b1;
                            end
                            else if (!drug2_set[fi]) begin
                                miss = 1'b1; what = MISS_DRUG2; where = 10'(fi); done = 1'b1;
                            end
                            else begin
                                a = drug_feat[fi];
                                b = drug2_feat[fi];
                                if (kind == KIND_PAIR_MIN)      v = (a < b) ? a : b;
                                else if (kind == KIND_PAIR_MAX) v = (a > b) ? a : b;
                                else                            v = (a + b) >>> 1;
                            end
                        end
                        else begin
                            st = ST_BAD_KIND;
                            done = 1'b1;
                        end
                        // below threshold goes left
                        if (!done)
                            idx = (v < longint'(node_thr[idx])) ? node_lnk[idx][19:10]
                                                                : node_lnk[idx][9:0];
                    end
                end
                if (!done)
                    st = ST_LONG_WALK;
            end
        end
        if (st == ST_OK && !miss)
            mean = 32'(acc / longint'(ntr));
        else
            mean = '0;
    endfunction

    // Apply an item to the image, attach its expected result and queue it
    function automatic void submit(req_t r);
        bit miss;
        logic [2:0] what;
        logic [9:0] where;
        case (r.op)
            OP_WRITE_NODE: begin
                node_ctl[r.addr]  = {r.leaf, r.kind, r.fidx};
                node_thr[r.addr]  = r.thr;
                node_lnk[r.addr]  = {r.lch, r.rch};
                node_lval[r.addr] = r.lval;
                node_set[r.addr]  = 1'b1;
            end
            OP_WRITE_FEATURE: begin
                if (r.addr < N_FEAT) begin
                    if (r.vsel == VSEL_CELL) begin
                        cell_feat[r.addr] = r.fval; cell_set[r.addr] = 1'b1;
                    end
                    else if (r.vsel == VSEL_DRUG) begin
                        drug_feat[r.addr] = r.fval; drug_set[r.addr] = 1'b1;
                    end
                    else if (r.vsel == VSEL_DRUG2) begin
                        drug2_feat[r.addr] = r.fval; drug2_set[r.addr] = 1'b1;
                    end
                end
            end
            OP_SET_ROOT: begin
                if (r.addr < N_TREES) begin
                    root_of[r.addr] = r.root;
                    root_set[r.addr] = 1'b1;
                end
            end
            default: begin
                walk_forest(r.st, r.mean, miss, what, where);
                r.has_pred = 1'b1;
                st_cnt[r.st]++;
            end
        endcase
        send_q.insert(send_q.size(), r);
        gen_cnt++;
    endfunction

    function automatic void put_node(logic [9:0] a, logic lf, logic [2:0] k, logic [7:0] fi,
                                     logic signed [31:0] th, logic [9:0] l, logic [9:0] rr,
                                     logic signed [31:0] lv);
        req_t r;
        r = rand_req();
        r.op = OP_WRITE_NODE; r.addr = a; r.leaf = lf; r.kind = k; r.fidx = fi;
        r.thr = th; r.lch = l; r.rch = rr; r.lval = lv;
        submit(r);
    endfunction

    function automatic void put_feat(logic [1:0] sel, logic [9:0] a, logic signed [31:0] v);
        req_t r;
        r = rand_req();
        r.op = OP_WRITE_FEATURE; r.vsel = sel; r.addr = a; r.fval = v;
        submit(r);
    endfunction

    function automatic void put_root(logic [9:0] t, logic [9:0] a);
        req_t r;
        r = rand_req();
        r.op = OP_SET_ROOT; r.addr = t; r.root = a;
        submit(r);
    endfunction

    function automatic void put_rand_node(logic [9:0] a, bit force_leaf);
        logic [2:0] k;
        if ($urandom_range(0, 99) < 85) begin
            if (reg_pair)
                k = ($urandom_range(0, 3) == 0) ? KIND_CELL : 3'($urandom_range(2, 4));
            else
                k = 3'($urandom_range(0, 1));
        end
        else
            k = 3'($urandom_range(0, 7));
        put_node(a, force_leaf || $urandom_range(0, 99) < 40, k,
                 8'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 7)
                                                 : $urandom_range(0, 255)),
                 rand_q(), pick_node(), pick_node(), rand_q());
    endfunction

    // Prediction: first write whatever the walk would read unwritten
    function automatic void put_predict();
        status_t st;
        logic signed [31:0] m;
        bit miss;
        logic [2:0] what;
        logic [9:0] where;
        req_t r;
        fill_depth = 0;
        walk_forest(st, m, miss, what, where);
        while (miss) begin
            case (what)
                MISS_ROOT:  put_root(where, pick_node());
                MISS_NODE:  put_rand_node(where, fill_depth > 20);
                MISS_CELL:  put_feat(VSEL_CELL, where, rand_q());
                MISS_DRUG:  put_feat(VSEL_DRUG, where, rand_q());
                default:    put_feat(VSEL_DRUG2, where, rand_q());
            endcase
            fill_depth++;
            walk_forest(st, m, miss, what, where);
        end
        r = rand_req();
        r.op = OP_PREDICT;
        submit(r);
    endfunction

    function automatic void rand_step();
        int r;
        req_t q;
        r = $urandom_range(0, 99);
        if (r < 35)
            put_predict();
        else if (r < 57)
            put_rand_node(pick_node(), 1'b0);
        else if (r < 75)
            put_feat(2'($urandom_range(0, 2)),
                     10'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 7)
                                                      : $urandom_range(0, 255)),
                     rand_q());
        else if (r < 85)
            put_root(10'($urandom_range(0, 63)), pick_node());
        else begin
            // raw write of any kind, out-of-range positions and selects included
            q = rand_req();
            q.op = op_t'($urandom_range(0, 2));
            submit(q);
        end
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_NUM_TREES: reg_trees = val[6:0];
            CFG_NUM_CELL:  reg_ncell = val;
            CFG_NUM_DRUG:  reg_ndrug = val;
            default:       reg_pair  = val[0];
        endcase
    endtask

    task automatic set_forest(int trees, int ncell, int ndrug, int pair);
        cfg_write(CFG_NUM_TREES, 9'(trees));
        cfg_write(CFG_NUM_CELL, 9'(ncell));
        cfg_write(CFG_NUM_DRUG, 9'(ndrug));
        cfg_write(CFG_PAIR_MODE, 9'(pair));
        phase_cnt++;
        gaps_on = ($urandom_range(0, 3) != 0);
    endtask

    task automatic drain();
        while (send_q.size() != 0 || mean_q.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic rand_items(int n);
        gen_cnt = 0;
        while (gen_cnt < n)
            rand_step();
    endtask

    // input driver
    always @(posedge clk or negedge rst_n) begin
        req_t r;
        pred_t pe;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap = 0;
        end
        else begin
            if (in_ch.valid && in_ch.ready)
                items_sent++;
            if (in_ch.valid && !in_ch.ready) begin
                // hold the item
            end
            else if (in_gap > 0) begin
                in_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (send_q.size() != 0) begin
                r = send_q.pop_front();
                if (r.has_pred) begin
                    pe.mean = r.mean;
                    pe.st   = r.st;
                    mean_q.insert(mean_q.size(), pe);
                end
                in_ch.valid               <= 1'b1;
                in_ch.operation           <= r.op;
                in_ch.target_address      <= r.addr;
                in_ch.node_is_leaf        <= r.leaf;
                in_ch.node_kind           <= r.kind;
                in_ch.split_feature_index <= r.fidx;
                in_ch.split_threshold     <= r.thr;
                in_ch.left_child          <= r.lch;
                in_ch.right_child         <= r.rch;
                in_ch.leaf_value          <= r.lval;
                in_ch.vector_select       <= r.vsel;
                in_ch.feature_value       <= r.fval;
                in_ch.root_address        <= r.root;
                in_gap = gap_len();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        pred_t e;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else begin
            if (out_ch.valid && out_ch.ready) begin
                if (mean_q.size() == 0) begin
                    mism_cnt++;
                    if (mism_cnt <= 10)
                        $display("unexpected result: prediction %h status %0d",
                                 out_ch.prediction, out_ch.status);
                end
                else begin
                    e = mean_q.pop_front();
                    if (out_ch.prediction !== e.mean || out_ch.status !== e.st) begin
                        mism_cnt++;
                        if (mism_cnt <= 10)
                            $display("mismatch: prediction %h (exp %h) status %0d (exp %0d)",
                                     out_ch.prediction, e.mean, out_ch.status, e.st);
                    end
                end
            end
            if (out_stall > 0) begin
                out_stall--;
                out_ch.ready <= 1'b0;
            end
            else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    out_stall = gap_len();
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            wdog = 0;
        else begin
            wdog++;
            if (wdog == WDOG_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        int p;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_WRITE_NODE;
        in_ch.target_address = '0;
        in_ch.node_is_leaf = 1'b0;
        in_ch.node_kind = KIND_CELL;
        in_ch.split_feature_index = '0;
        in_ch.split_threshold = '0;
        in_ch.left_child = '0;
        in_ch.right_child = '0;
        in_ch.leaf_value = '0;
        in_ch.vector_select = VSEL_CELL;
        in_ch.feature_value = '0;
        in_ch.root_address = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_NUM_TREES;
        cfg_ch.data = '0;
        reg_trees = 7'd1;
        reg_ncell = '0;
        reg_ndrug = '0;
        reg_pair = 1'b0;
        mism_cnt = 0;
        items_sent = 0;
        phase_cnt = 0;
        wdog = 0;
        gaps_on = 1'b1;
        foreach (st_cnt[i]) st_cnt[i] = 0;
        foreach (node_set[i]) node_set[i] = 1'b0;
        foreach (root_set[i]) root_set[i] = 1'b0;
        foreach (cell_set[i]) begin
            cell_set[i] = 1'b0; drug_set[i] = 1'b0; drug2_set[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single mode: extremes, ignored writes, every error status
        set_forest(2, 8, 8, 0);
        put_feat(VSEL_CELL, 0, 32'sh7FFFFFFF);
        put_feat(VSEL_CELL, 7, 32'sh80000000);
        put_feat(VSEL_DRUG, 0, 0);
        put_feat(VSEL_DRUG2, 0, 1);
        put_feat(2'd3, 1, 5);
        put_feat(VSEL_CELL, 1023, 9);
        put_node(1023, 1, KIND_CELL, 0, 0, 0, 0, 32'sh7FFFFFFF);
        put_node(0, 1, KIND_CELL, 0, 0, 0, 0, 32'sh80000000);
        put_node(5, 0, KIND_CELL, 0, 0, 0, 1023, 0);
        put_root(0, 5);
        put_root(1, 0);
        put_root(1000, 1023);
        put_predict();
        put_node(6, 0, KIND_CELL, 255, 0, 0, 0, 0);
        put_root(0, 6);
        put_predict();
        put_node(7, 0, 3'd7, 0, 0, 0, 0, 0);
        put_root(0, 7);
        put_predict();
        put_node(9, 0, KIND_CELL, 7, 32'sh7FFFFFFF, 9, 9, 0);
        put_root(0, 9);
        put_predict();
        put_node(10, 0, KIND_DRUG, 0, 1, 1023, 0, 0);
        put_root(0, 10);
        put_predict();
        rand_items(60);
        drain();

        // pair mode: min, max, floor average of an odd negative sum, drug kind invalid
        set_forest(3, 8, 8, 1);
        put_feat(VSEL_DRUG, 1, -32'sd3);
        put_feat(VSEL_DRUG2, 1, 0);
        put_node(11, 0, KIND_PAIR_AVG, 1, -32'sd1, 0, 1023, 0);
        put_node(12, 0, KIND_PAIR_MIN, 1, -32'sd2, 0, 1023, 0);
        put_node(13, 0, KIND_PAIR_MAX, 1, 0, 1023, 0, 0);
        put_root(0, 11);
        put_root(1, 12);
        put_root(2, 13);
        put_predict();
        put_node(14, 0, KIND_DRUG, 1, 0, 0, 0, 0);
        put_root(2, 14);
        put_predict();
        rand_items(60);
        drain();

        // register extremes
        set_forest(0, 0, 256, 1);
        rand_items(80);
        drain();
        set_forest(64, 256, 0, 0);
        rand_items(80);
        drain();
        set_forest(127, 511, 511, 1);
        rand_items(70);
        drain();

        for (p = 0; p < 8; p++) begin
            set_forest(($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8),
                       ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(0, 12),
                       ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(0, 12),
                       $urandom_range(0, 1));
            rand_items(100);
            drain();
        end

        $display("%0d items over %0d register settings; %0d predictions ok, %0d bad index,",
                 items_sent, phase_cnt, st_cnt[ST_OK], st_cnt[ST_BAD_INDEX]);
        $display("%0d bad kind, %0d long walk; %0d mismatches",
                 st_cnt[ST_BAD_KIND], st_cnt[ST_LONG_WALK], mism_cnt);
        if (mism_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fti_pkg.sv
hdl/fti_stream_if.sv
hdl/forest_tree_inference_core.sv
sim/tb_top.sv
